// ----- rtl/ila_pkg.sv -----
// Shared constants, codes and control/status types of the implicit list allocator.
`default_nettype none
package ila_pkg;

  localparam int GRANULES = 4096;
  localparam int IDX_W    = $clog2(GRANULES);
  localparam int GSZ_W    = IDX_W + 1;
  localparam int TAG_W    = GSZ_W + 1;
  localparam int CFG_W    = 17;
  localparam int OP_W     = 5;

  localparam logic [2:0] CMD_ALLOC   = 3'd0;
  localparam logic [2:0] CMD_FREE    = 3'd1;
  localparam logic [2:0] CMD_REALLOC = 3'd2;
  localparam logic [2:0] CMD_CALLOC  = 3'd3;
  localparam logic [2:0] CMD_BEGIN   = 3'd4;
  localparam logic [2:0] CMD_END     = 3'd5;

  localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
  localparam logic [OP_W-1:0] OP_PREP      = 5'd2;
  localparam logic [OP_W-1:0] OP_BEGIN0    = 5'd3;
  localparam logic [OP_W-1:0] OP_BEGIN1    = 5'd4;
  localparam logic [OP_W-1:0] OP_END       = 5'd5;
  localparam logic [OP_W-1:0] OP_FAIL_OOM  = 5'd6;
  localparam logic [OP_W-1:0] OP_SET_OK    = 5'd7;
  localparam logic [OP_W-1:0] OP_WALK0     = 5'd8;
  localparam logic [OP_W-1:0] OP_RD_B      = 5'd9;
  localparam logic [OP_W-1:0] OP_STEP      = 5'd10;
  localparam logic [OP_W-1:0] OP_ALLOC_HIT = 5'd11;
  localparam logic [OP_W-1:0] OP_AW0       = 5'd12;
  localparam logic [OP_W-1:0] OP_AW1       = 5'd13;
  localparam logic [OP_W-1:0] OP_AW2       = 5'd14;
  localparam logic [OP_W-1:0] OP_AW3       = 5'd15;
  localparam logic [OP_W-1:0] OP_LIVE_HIT  = 5'd16;
  localparam logic [OP_W-1:0] OP_INPLACE   = 5'd17;
  localparam logic [OP_W-1:0] OP_FREE_INIT = 5'd18;
  localparam logic [OP_W-1:0] OP_RD_N      = 5'd19;
  localparam logic [OP_W-1:0] OP_CK_N      = 5'd20;
  localparam logic [OP_W-1:0] OP_RD_P      = 5'd21;
  localparam logic [OP_W-1:0] OP_CK_P      = 5'd22;
  localparam logic [OP_W-1:0] OP_RD_Q      = 5'd23;
  localparam logic [OP_W-1:0] OP_CK_Q      = 5'd24;
  localparam logic [OP_W-1:0] OP_FW0       = 5'd25;
  localparam logic [OP_W-1:0] OP_FW1       = 5'd26;
  localparam logic [OP_W-1:0] OP_EMIT      = 5'd27;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       addr_null;
    logic       addr_bad;
    logic       size_zero;
    logic       fits_inplace;
    logic       need_bad;
    logic       begin_bad;
    logic       walk_end;
    logic       tag_bad;
    logic       fit;
    logic       at_target;
    logic       past_target;
    logic       tag_used;
    logic       split;
    logic       nxt_in;
    logic       b_nonzero;
    logic       psz_ok;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/ila_dpath.sv -----
// Datapath of the implicit list allocator: tag memory, walk registers and result registers.
`default_nettype none
module ila_dpath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [ila_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic [2:0]                in_cmd,
  input  logic [15:0]               in_addr,
  input  logic [31:0]               in_size,
  input  logic [31:0]               in_count,
  input  ila_pkg::ctl_t             ctl,
  output ila_pkg::sts_t             sts,
  output logic [15:0]               result_addr,
  output logic                      ok,
  output logic                      oom,
  output logic [15:0]               copy_from,
  output logic [15:0]               copy_len,
  output logic [15:0]               clear_len
);
  import ila_pkg::*;

  logic [TAG_W-1:0] tag_mem [0:GRANULES-1];
  logic [TAG_W-1:0] rdata;

  logic [2:0]       cmd;
  logic [15:0]      addr;
  logic [31:0]      size;
  logic [31:0]      count;
  logic [63:0]      n;
  logic [IDX_W-1:0] g_tgt;
  logic [GSZ_W-1:0] b;
  logic [GSZ_W-1:0] fsz;
  logic [GSZ_W-1:0] gsz;
  logic [GSZ_W-1:0] psz;
  logic [15:0]      res_addr;
  logic             res_ok;
  logic [15:0]      res_cfrom;
  logic [15:0]      res_clen;
  logic [15:0]      res_zlen;

  logic [GSZ_W-1:0] ag;
  logic             active;
  logic             oom_flag;
  logic [CFG_W-1:0] arena_bytes;

  logic [GSZ_W-1:0] tsz;
  logic             tused;
  logic [17:0]      need_sum;
  logic [13:0]      need14;
  logic [GSZ_W-1:0] need;
  logic [17:0]      bg_sum;
  logic [13:0]      bg_raw;
  logic [13:0]      bg;
  logic [16:0]      cur;
  logic             split;
  logic [GSZ_W-1:0] asz;
  logic [GSZ_W:0]   nxt;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [TAG_W-1:0] wdata;
  logic             re;
  logic [IDX_W-1:0] raddr;

  assign tsz      = rdata[TAG_W-1:1];
  assign tused    = rdata[0];
  assign need_sum = {1'b0, n[16:0]} + 18'd47;
  assign need14   = need_sum[17:4];
  assign need     = need14[GSZ_W-1:0];
  assign bg_sum   = {1'b0, arena_bytes} + 18'd15;
  assign bg_raw   = bg_sum[17:4];
  assign bg       = (bg_raw > 14'(GRANULES)) ? 14'(GRANULES) : bg_raw;
  assign cur      = {gsz, 4'b0000} - 17'd32;
  assign split    = {1'b0, fsz} >= ({1'b0, need} + 14'd3);
  assign asz      = split ? need : fsz;
  assign nxt      = {1'b0, b} + {1'b0, fsz};

  always_comb begin
    sts.cmd          = cmd;
    sts.addr_null    = (addr == 16'd0);
    sts.addr_bad     = !active || (addr < 16'd16) || (addr[3:0] != 4'd0) ||
                       ({1'b0, g_tgt} >= ag);
    sts.size_zero    = (size == 32'd0);
    sts.fits_inplace = (size <= {15'd0, cur});
    sts.need_bad     = !active || (|n[63:17]) || (need14 > {1'b0, ag});
    sts.begin_bad    = (bg < 14'd2);
    sts.walk_end     = (b >= ag);
    sts.tag_bad      = (tsz < 13'd2) || (tsz > (ag - b));
    sts.fit          = !tused && (tsz >= need);
    sts.at_target    = (b == {1'b0, g_tgt});
    sts.past_target  = (b > {1'b0, g_tgt});
    sts.tag_used     = tused;
    sts.split        = split;
    sts.nxt_in       = (nxt < {1'b0, ag});
    sts.b_nonzero    = (b != '0);
    sts.psz_ok       = (psz >= 13'd2) && (psz <= b);
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;
    case (ctl.op)
      OP_BEGIN0: begin
        we    = 1'b1;
        wdata = {bg[GSZ_W-1:0], 1'b0};
      end
      OP_BEGIN1: begin
        we    = 1'b1;
        waddr = IDX_W'(ag - 13'd1);
        wdata = {ag, 1'b0};
      end
      OP_AW0: begin
        we    = 1'b1;
        waddr = b[IDX_W-1:0];
        wdata = {asz, 1'b1};
      end
      OP_AW1: begin
        we    = 1'b1;
        waddr = IDX_W'(b + asz - 13'd1);
        wdata = {asz, 1'b0};
      end
      OP_AW2: begin
        we    = 1'b1;
        waddr = IDX_W'(b + need);
        wdata = {fsz - need, 1'b0};
      end
      OP_AW3: begin
        we    = 1'b1;
        waddr = IDX_W'(b + fsz - 13'd1);
        wdata = {fsz - need, 1'b0};
      end
      OP_FW0: begin
        we    = 1'b1;
        waddr = b[IDX_W-1:0];
        wdata = {fsz, 1'b0};
      end
      OP_FW1: begin
        we    = 1'b1;
        waddr = IDX_W'(b + fsz - 13'd1);
        wdata = {fsz, 1'b0};
      end
      OP_RD_B: begin
        re    = 1'b1;
        raddr = b[IDX_W-1:0];
      end
      OP_RD_N: begin
        re    = 1'b1;
        raddr = nxt[IDX_W-1:0];
      end
      OP_RD_P: begin
        re    = 1'b1;
        raddr = IDX_W'(b - 13'd1);
      end
      OP_RD_Q: begin
        re    = 1'b1;
        raddr = IDX_W'(b - psz);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tag_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= tag_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ag          <= '0;
      active      <= 1'b0;
      oom_flag    <= 1'b0;
      arena_bytes <= CFG_W'(65536);
    end else begin
      if (cfg_wr_en) begin
        arena_bytes <= cfg_wr_data;
      end
      case (ctl.op)
        OP_BEGIN0: begin
          ag       <= bg[GSZ_W-1:0];
          active   <= 1'b1;
          oom_flag <= 1'b0;
        end
        OP_END: begin
          ag       <= '0;
          active   <= 1'b0;
          oom_flag <= 1'b0;
        end
        OP_FAIL_OOM: oom_flag <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        cmd       <= in_cmd;
        addr      <= in_addr;
        size      <= in_size;
        count     <= in_count;
        res_addr  <= '0;
        res_ok    <= 1'b0;
        res_cfrom <= '0;
        res_clen  <= '0;
        res_zlen  <= '0;
      end
      OP_PREP: begin
        n     <= (cmd == CMD_CALLOC) ? (64'(size) * 64'(count)) : 64'(size);
        g_tgt <= addr[15:4] - 12'd1;
      end
      OP_BEGIN0, OP_END, OP_SET_OK: res_ok <= 1'b1;
      OP_WALK0: b <= '0;
      OP_STEP:  b <= b + tsz;
      OP_ALLOC_HIT: begin
        fsz      <= tsz;
        res_addr <= {b[IDX_W-1:0], 4'b0000} + 16'd16;
        res_ok   <= 1'b1;
        res_zlen <= (cmd == CMD_CALLOC) ? n[15:0] : 16'd0;
        if (cmd == CMD_REALLOC && addr != 16'd0) begin
          res_cfrom <= addr;
          res_clen  <= cur[15:0];
        end
      end
      OP_LIVE_HIT: gsz <= tsz;
      OP_INPLACE: begin
        res_addr <= addr;
        res_ok   <= 1'b1;
      end
      OP_FREE_INIT: begin
        b      <= {1'b0, g_tgt};
        fsz    <= gsz;
        res_ok <= 1'b1;
      end
      OP_CK_N: begin
        if (!tused) begin
          fsz <= fsz + tsz;
        end
      end
      OP_CK_P: psz <= tsz;
      OP_CK_Q: begin
        if (!tused) begin
          b   <= b - psz;
          fsz <= fsz + psz;
        end
      end
      OP_EMIT: begin
        result_addr <= res_addr;
        ok          <= res_ok;
        oom         <= oom_flag;
        copy_from   <= res_cfrom;
        copy_len    <= res_clen;
        clear_len   <= res_zlen;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/ila_ctrl.sv -----
// Controller state machine of the implicit list allocator.
`default_nettype none
module ila_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ila_pkg::sts_t sts,
  output ila_pkg::ctl_t ctl
);
  import ila_pkg::*;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_PREP   = 5'd1;
  localparam logic [4:0] ST_DECODE = 5'd2;
  localparam logic [4:0] ST_BEGIN1 = 5'd3;
  localparam logic [4:0] ST_A_RD   = 5'd4;
  localparam logic [4:0] ST_A_CK   = 5'd5;
  localparam logic [4:0] ST_AW0    = 5'd6;
  localparam logic [4:0] ST_AW1    = 5'd7;
  localparam logic [4:0] ST_AW2    = 5'd8;
  localparam logic [4:0] ST_AW3    = 5'd9;
  localparam logic [4:0] ST_L_RD   = 5'd10;
  localparam logic [4:0] ST_L_CK   = 5'd11;
  localparam logic [4:0] ST_R_DEC  = 5'd12;
  localparam logic [4:0] ST_FREE   = 5'd13;
  localparam logic [4:0] ST_F_RDN  = 5'd14;
  localparam logic [4:0] ST_F_CKN  = 5'd15;
  localparam logic [4:0] ST_F_RDP  = 5'd16;
  localparam logic [4:0] ST_F_CKP  = 5'd17;
  localparam logic [4:0] ST_F_RDQ  = 5'd18;
  localparam logic [4:0] ST_F_CKQ  = 5'd19;
  localparam logic [4:0] ST_FW0    = 5'd20;
  localparam logic [4:0] ST_FW1    = 5'd21;
  localparam logic [4:0] ST_DONE   = 5'd22;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       out_valid_next;
  logic [4:0] after_alloc;
  logic       emit;

  assign in_ready    = (state == ST_IDLE);
  assign after_alloc = (sts.cmd == CMD_REALLOC && !sts.addr_null) ? ST_FREE : ST_DONE;
  assign emit        = (ctl.op == OP_EMIT);

  always_comb begin
    state_next = state;
    ctl.op     = OP_NOP;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.op     = OP_LOAD;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        ctl.op     = OP_PREP;
        state_next = ST_DECODE;
      end
      ST_DECODE: begin
        state_next = ST_DONE;
        case (sts.cmd)
          CMD_ALLOC, CMD_CALLOC: begin
            if (sts.need_bad) begin
              ctl.op = OP_FAIL_OOM;
            end else begin
              ctl.op     = OP_WALK0;
              state_next = ST_A_RD;
            end
          end
          CMD_FREE: begin
            if (sts.addr_null) begin
              ctl.op = OP_SET_OK;
            end else if (!sts.addr_bad) begin
              ctl.op     = OP_WALK0;
              state_next = ST_L_RD;
            end
          end
          CMD_REALLOC: begin
            if (sts.addr_null) begin
              if (sts.need_bad) begin
                ctl.op = OP_FAIL_OOM;
              end else begin
                ctl.op     = OP_WALK0;
                state_next = ST_A_RD;
              end
            end else if (!sts.addr_bad) begin
              ctl.op     = OP_WALK0;
              state_next = ST_L_RD;
            end
          end
          CMD_BEGIN: begin
            if (!sts.begin_bad) begin
              ctl.op     = OP_BEGIN0;
              state_next = ST_BEGIN1;
            end
          end
          CMD_END: ctl.op = OP_END;
          default: begin
          end
        endcase
      end
      ST_BEGIN1: begin
        ctl.op     = OP_BEGIN1;
        state_next = ST_DONE;
      end
      ST_A_RD: begin
        if (sts.walk_end) begin
          ctl.op     = OP_FAIL_OOM;
          state_next = ST_DONE;
        end else begin
          ctl.op     = OP_RD_B;
          state_next = ST_A_CK;
        end
      end
      ST_A_CK: begin
        if (sts.tag_bad) begin
          ctl.op     = OP_FAIL_OOM;
          state_next = ST_DONE;
        end else if (sts.fit) begin
          ctl.op     = OP_ALLOC_HIT;
          state_next = ST_AW0;
        end else begin
          ctl.op     = OP_STEP;
          state_next = ST_A_RD;
        end
      end
      ST_AW0: begin
        ctl.op     = OP_AW0;
        state_next = ST_AW1;
      end
      ST_AW1: begin
        ctl.op     = OP_AW1;
        state_next = sts.split ? ST_AW2 : after_alloc;
      end
      ST_AW2: begin
        ctl.op     = OP_AW2;
        state_next = ST_AW3;
      end
      ST_AW3: begin
        ctl.op     = OP_AW3;
        state_next = after_alloc;
      end
      ST_L_RD: begin
        if (sts.walk_end) begin
          state_next = ST_DONE;
        end else begin
          ctl.op     = OP_RD_B;
          state_next = ST_L_CK;
        end
      end
      ST_L_CK: begin
        if (sts.tag_bad || sts.past_target) begin
          state_next = ST_DONE;
        end else if (sts.at_target) begin
          if (sts.tag_used) begin
            ctl.op     = OP_LIVE_HIT;
            state_next = (sts.cmd == CMD_REALLOC) ? ST_R_DEC : ST_FREE;
          end else begin
            state_next = ST_DONE;
          end
        end else begin
          ctl.op     = OP_STEP;
          state_next = ST_L_RD;
        end
      end
      ST_R_DEC: begin
        if (sts.size_zero) begin
          state_next = ST_FREE;
        end else if (sts.fits_inplace) begin
          ctl.op     = OP_INPLACE;
          state_next = ST_DONE;
        end else if (sts.need_bad) begin
          ctl.op     = OP_FAIL_OOM;
          state_next = ST_DONE;
        end else begin
          ctl.op     = OP_WALK0;
          state_next = ST_A_RD;
        end
      end
      ST_FREE: begin
        ctl.op     = OP_FREE_INIT;
        state_next = ST_F_RDN;
      end
      ST_F_RDN: begin
        if (sts.nxt_in) begin
          ctl.op     = OP_RD_N;
          state_next = ST_F_CKN;
        end else begin
          state_next = ST_F_RDP;
        end
      end
      ST_F_CKN: begin
        ctl.op     = OP_CK_N;
        state_next = ST_F_RDP;
      end
      ST_F_RDP: begin
        if (sts.b_nonzero) begin
          ctl.op     = OP_RD_P;
          state_next = ST_F_CKP;
        end else begin
          state_next = ST_FW0;
        end
      end
      ST_F_CKP: begin
        ctl.op     = OP_CK_P;
        state_next = ST_F_RDQ;
      end
      ST_F_RDQ: begin
        if (sts.psz_ok) begin
          ctl.op     = OP_RD_Q;
          state_next = ST_F_CKQ;
        end else begin
          state_next = ST_FW0;
        end
      end
      ST_F_CKQ: begin
        ctl.op     = OP_CK_Q;
        state_next = ST_FW0;
      end
      ST_FW0: begin
        ctl.op     = OP_FW0;
        state_next = ST_FW1;
      end
      ST_FW1: begin
        ctl.op     = OP_FW1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.op     = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready))
    else $error("result emitted over an untaken word");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_PREP))
    else $error("accepted word did not start a command");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && !out_ready) |=> (state == ST_DONE && out_valid))
    else $error("finished command lost while output stalled");

endmodule
`default_nettype wire

// ----- rtl/implicit_list_allocator_core.sv -----
// Top level of the implicit list allocator: stream ports, controller and datapath.
`default_nettype none
// One command word is taken at a time. All block tags live in one tag memory,
// which the controller gives one read or one write per cycle. Alloc and calloc
// walk the block headers from the arena start to the first fitting block and
// then write two or four tags; free and realloc first walk to the given block
// to check it, and a free then reads the tags of its neighbors to merge with
// them and writes the two tags of the merged block. Begin writes the two tags
// of one free block that spans the arena, and end closes the arena. The result
// word is held in an output register, so a new command is taken while it waits.
module implicit_list_allocator_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [ila_pkg::CFG_W-1:0] cfg_wr_data,  // arena_bytes
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [79:0]               s_axis_tdata,  // addr, size_bytes, item_count
  input  logic [2:0]                s_axis_tuser,  // cmd
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // result_addr, ok, oom, copy_from, copy_len, clear_len, zero fill
  output logic [71:0]               m_axis_tdata
);
  import ila_pkg::*;

  ctl_t        ctl;
  sts_t        sts;
  logic [15:0] result_addr;
  logic        ok;
  logic        oom;
  logic [15:0] copy_from;
  logic [15:0] copy_len;
  logic [15:0] clear_len;

  ila_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  ila_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_cmd      (s_axis_tuser),
    .in_addr     (s_axis_tdata[15:0]),
    .in_size     (s_axis_tdata[47:16]),
    .in_count    (s_axis_tdata[79:48]),
    .ctl         (ctl),
    .sts         (sts),
    .result_addr (result_addr),
    .ok          (ok),
    .oom         (oom),
    .copy_from   (copy_from),
    .copy_len    (copy_len),
    .clear_len   (clear_len)
  );

  assign m_axis_tdata = {6'd0, clear_len, copy_len, copy_from, oom, ok, result_addr};

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the implicit list allocator core.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ila_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [15:0] clear_len;
    logic [15:0] copy_len;
    logic [15:0] copy_from;
    logic        oom;
    logic        ok;
    logic [15:0] result_addr;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  implicit_list_allocator_core dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #6 clk = ~clk;

  // Shadow copy of the allocator state.
  logic [13:0] tags[GRANULES];
  int unsigned arena_size_cfg;
  int unsigned heap_granules;
  bit heap_active;
  bit oom_sticky;
  alloc_result_t pending_results[$];
  int unsigned live_blocks[$];
  int errors = 0;
  bit quiet_sink = 0;
  longint unsigned cycles = 0;

  function automatic int unsigned tag_size(int unsigned g);
    return g < GRANULES ? tags[g] >> 1 : 0;
  endfunction

  function automatic bit tag_used(int unsigned g);
    return g < GRANULES ? tags[g][0] : 1'b0;
  endfunction

  function automatic void write_block(int unsigned g, int unsigned sz, bit used);
    int unsigned f;
    f = g + sz - 1;
    if (g < GRANULES) tags[g] = {sz[12:0], used};
    if (sz >= 2 && f < GRANULES) tags[f] = {sz[12:0], 1'b0};
  endfunction

  function automatic bit is_live(int unsigned g);
    int unsigned b, sz;
    b = 0;
    while (b < heap_granules) begin
      sz = tag_size(b);
      if (sz < 2 || sz > heap_granules - b) return 0;
      if (b == g) return tag_used(b);
      if (b > g) return 0;
      b += sz;
    end
    return 0;
  endfunction

  function automatic int unsigned first_free_block(int unsigned need);
    int unsigned b, sz;
    b = 0;
    while (b < heap_granules) begin
      sz = tag_size(b);
      if (sz < 2 || sz > heap_granules - b) return heap_granules;
      if (!tag_used(b) && sz >= need) return b;
      b += sz;
    end
    return heap_granules;
  endfunction

  function automatic int unsigned take_block(longint unsigned n);
    longint unsigned need;
    int unsigned b, sz;
    if (!heap_active) begin oom_sticky = 1; return 0; end
    need = (n + 47) >> 4;
    if (need > heap_granules) begin oom_sticky = 1; return 0; end
    b = first_free_block(need);
    if (b >= heap_granules) begin oom_sticky = 1; return 0; end
    sz = tag_size(b);
    if (sz >= need + 3) begin
      write_block(b, need, 1);
      write_block(b + need, sz - need, 0);
    end else begin
      write_block(b, sz, 1);
    end
    return (b + 1) << 4;
  endfunction

  function automatic void release_block(int unsigned b);
    int unsigned sz, nxt, psz;
    sz = tag_size(b);
    nxt = b + sz;
    if (nxt < heap_granules && !tag_used(nxt)) sz += tag_size(nxt);
    if (b > 0) begin
      psz = tag_size(b - 1);
      if (psz >= 2 && psz <= b && !tag_used(b - psz)) begin
        b -= psz;
        sz += psz;
      end
    end
    write_block(b, sz, 0);
  endfunction

  function automatic int unsigned payload_block(int unsigned a);
    int unsigned g;
    if (!heap_active || a < 16 || a[3:0] != 0) return heap_granules;
    g = (a >> 4) - 1;
    if (g >= heap_granules || !is_live(g)) return heap_granules;
    return g;
  endfunction

  function automatic alloc_result_t predict_command(logic [2:0] cmd, int unsigned a,
                                                    longint unsigned sz,
                                                    longint unsigned cnt);
    alloc_result_t r;
    int unsigned g, cur, res;
    longint unsigned prod;
    r = '0;
    res = 0;
    case (cmd)
      CMD_ALLOC: begin
        res = take_block(sz);
        r.ok = res != 0;
      end
      CMD_FREE: begin
        if (a == 0) r.ok = 1;
        else begin
          g = payload_block(a);
          if (g < heap_granules) begin release_block(g); r.ok = 1; end
        end
      end
      CMD_REALLOC: begin
        if (a == 0) begin
          res = take_block(sz);
          r.ok = res != 0;
        end else begin
          g = payload_block(a);
          if (g < heap_granules) begin
            cur = (tag_size(g) << 4) - 32;
            if (sz == 0) begin
              release_block(g);
              r.ok = 1;
            end else if (sz <= cur) begin
              res = a;
              r.ok = 1;
            end else begin
              res = take_block(sz);
              if (res != 0) begin
                r.copy_from = a;
                r.copy_len = cur;
                release_block(g);
                r.ok = 1;
              end
            end
          end
        end
      end
      CMD_CALLOC: begin
        prod = sz * cnt;
        res = take_block(prod);
        if (res != 0) begin r.ok = 1; r.clear_len = prod[15:0]; end
      end
      CMD_BEGIN: begin
        g = (arena_size_cfg + 15) >> 4;
        if (g > GRANULES) g = GRANULES;
        if (g >= 2) begin
          heap_granules = g;
          heap_active = 1;
          oom_sticky = 0;
          write_block(0, g, 0);
          r.ok = 1;
        end
      end
      CMD_END: begin
        heap_active = 0;
        heap_granules = 0;
        oom_sticky = 0;
        r.ok = 1;
      end
      default: ;
    endcase
    r.result_addr = res[15:0];
    r.oom = oom_sticky;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) m_axis_tready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    alloc_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[65:0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.result_addr !== want.result_addr)
          $display("%0t: result_addr expected %h actual %h", $time,
                   want.result_addr, got.result_addr);
        if (got.ok !== want.ok)
          $display("%0t: ok expected %b actual %b", $time, want.ok, got.ok);
        if (got.oom !== want.oom)
          $display("%0t: oom expected %b actual %b", $time, want.oom, got.oom);
        if (got.copy_from !== want.copy_from)
          $display("%0t: copy_from expected %h actual %h", $time,
                   want.copy_from, got.copy_from);
        if (got.copy_len !== want.copy_len)
          $display("%0t: copy_len expected %h actual %h", $time,
                   want.copy_len, got.copy_len);
        if (got.clear_len !== want.clear_len)
          $display("%0t: clear_len expected %h actual %h", $time,
                   want.clear_len, got.clear_len);
        if (got !== want) errors++;
      end
    end
  end

  task automatic send_command(logic [2:0] cmd, logic [15:0] a, logic [31:0] sz,
                              logic [31:0] cnt = 32'd0);
    alloc_result_t r;
    while (!quiet_sink && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {cnt, sz, a};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = predict_command(cmd, a, sz, cnt);
    pending_results.push_back(r);
    if (r.ok && r.result_addr != 0) live_blocks.push_back(r.result_addr);
  endtask

  task automatic drain;
    int unsigned k;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    for (k = 0; k < 64; k++) @(posedge clk);
  endtask

  task automatic set_arena(int unsigned bytes);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= bytes[CFG_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    arena_size_cfg = bytes;
  endtask

  function automatic logic [15:0] pick_address();
    int unsigned i;
    if (live_blocks.size() == 0 || $urandom_range(9) == 0) return $urandom;
    i = $urandom_range(live_blocks.size() - 1);
    pick_address = live_blocks[i];
    if ($urandom_range(3) != 0) live_blocks.delete(i);
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom;
      2: return $urandom_range(4000);
      default: return $urandom_range(300);
    endcase
  endfunction

  task automatic test_idle_arena;
    send_command(CMD_ALLOC, 16'd0, 32'd16);
    send_command(CMD_FREE, 16'd0, 32'd0);
    send_command(CMD_FREE, 16'd32, 32'd0);
    send_command(CMD_REALLOC, 16'd48, 32'd8);
    send_command(CMD_REALLOC, 16'd0, 32'd8);
    send_command(CMD_CALLOC, 16'd0, 32'd2, 32'd3);
    send_command(3'd6, 16'hffff, 32'hffffffff, 32'hffffffff);
    send_command(3'd7, 16'd0, 32'd0, 32'd0);
  endtask

  task automatic test_special_cases;
    set_arena(31);
    send_command(CMD_BEGIN, 16'd0, 32'd0);
    set_arena(17);
    send_command(CMD_BEGIN, 16'd0, 32'd0);
    set_arena(32);
    send_command(CMD_BEGIN, 16'd0, 32'd0);
    send_command(CMD_ALLOC, 16'd0, 32'd1);
    send_command(CMD_ALLOC, 16'd0, 32'd0);
    send_command(CMD_END, 16'd0, 32'd0);
    set_arena(65536);
    send_command(CMD_BEGIN, 16'd0, 32'd0);
    send_command(CMD_ALLOC, 16'd0, 32'hffffffff);
    send_command(CMD_CALLOC, 16'd0, 32'hffffffff, 32'hffffffff);
    send_command(CMD_CALLOC, 16'd0, 32'd100, 32'd10);
    send_command(CMD_ALLOC, 16'd0, 32'd40);
    send_command(CMD_ALLOC, 16'd0, 32'd40);
    send_command(CMD_REALLOC, 16'd1616, 32'd8);
    send_command(CMD_REALLOC, 16'd1616, 32'd300);
    send_command(CMD_FREE, 16'd1617, 32'd0);
    send_command(CMD_FREE, 16'd1616, 32'd0);
    send_command(CMD_FREE, 16'd16, 32'd0);
    send_command(CMD_REALLOC, 16'd1696, 32'd0);
    send_command(CMD_ALLOC, 16'd0, 32'd65504);
    live_blocks.delete();
  endtask

  task automatic test_random_traffic(int unsigned count);
    int unsigned i;
    logic [2:0] cmd;
    for (i = 0; i < count; i++) begin
      if (i == count / 3) quiet_sink = 1;
      if (i == count / 2) quiet_sink = 0;
      if (i % 150 == 149) begin
        set_arena($urandom_range(3) == 0 ? $urandom_range(65536, 32) :
                  $urandom_range(4096, 32));
        live_blocks.delete();
        send_command(CMD_BEGIN, 16'd0, 32'd0);
      end
      case ($urandom_range(99)) inside
        [0:34]: cmd = CMD_ALLOC;
        [35:64]: cmd = CMD_FREE;
        [65:84]: cmd = CMD_REALLOC;
        [85:93]: cmd = CMD_CALLOC;
        [94:96]: cmd = CMD_BEGIN;
        [97:98]: cmd = CMD_END;
        default: cmd = 3'($urandom_range(7, 6));
      endcase
      if (cmd == CMD_BEGIN || cmd == CMD_END) live_blocks.delete();
      if (cmd == CMD_CALLOC)
        send_command(cmd, $urandom, $urandom_range(3) == 0 ? $urandom : $urandom_range(40),
                     $urandom_range(3) == 0 ? $urandom : $urandom_range(20));
      else
        send_command(cmd, (cmd == CMD_FREE || cmd == CMD_REALLOC) ? pick_address() :
                     16'($urandom), pick_size(), $urandom);
    end
  endtask

  initial begin
    arena_size_cfg = 65536;
    heap_granules = 0;
    heap_active = 0;
    oom_sticky = 0;
    foreach (tags[i]) tags[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_idle_arena();
    test_special_cases();
    test_random_traffic(750);
    drain();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
